// File: design/salru_pkg.sv
// ----------------------------------------------------------------------------
// salru_pkg
// Shared types and constants of the set-associative write-back cache tag
// store: request op codes, the result word and default geometry.
// ----------------------------------------------------------------------------
package salru_pkg;

  localparam int ADDR_BITS        = 32;
  localparam int OFS_BITS_DEF     = 5;
  localparam int SET_BITS_DEF     = 8;
  localparam int WAYS_DEF         = 4;

  typedef logic [1:0]           op_t;
  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [1:0]           way_out_t;

  localparam op_t OP_READ  = 2'd0;
  localparam op_t OP_WRITE = 2'd1;
  localparam op_t OP_INVAL = 2'd2;

  typedef struct packed {
    logic     hit;
    way_out_t way;
    logic     fill_request;
    addr_t    fill_address;
    logic     writeback_request;
    addr_t    writeback_address;
    logic     invalidated_dirty;
  } rsp_t;

endpackage

// File: design/salru_req_if.sv
// ----------------------------------------------------------------------------
// salru_req_if
// Request channel: valid/ready handshake carrying op and byte address.
// ----------------------------------------------------------------------------
interface salru_req_if;
  logic             valid;
  logic             ready;
  salru_pkg::op_t   op;
  salru_pkg::addr_t address;

  modport source (output valid, output op, output address, input ready);
  modport sink   (input valid, input op, input address, output ready);
endinterface

// File: design/salru_rsp_if.sv
// ----------------------------------------------------------------------------
// salru_rsp_if
// Result channel: valid/ready handshake carrying one lookup result word.
// ----------------------------------------------------------------------------
interface salru_rsp_if;
  logic                valid;
  logic                ready;
  logic                hit;
  salru_pkg::way_out_t way;
  logic                fill_request;
  salru_pkg::addr_t    fill_address;
  logic                writeback_request;
  salru_pkg::addr_t    writeback_address;
  logic                invalidated_dirty;

  modport source (output valid, output hit, output way, output fill_request,
                  output fill_address, output writeback_request,
                  output writeback_address, output invalidated_dirty,
                  input ready);
  modport sink   (input valid, input hit, input way, input fill_request,
                  input fill_address, input writeback_request,
                  input writeback_address, input invalidated_dirty,
                  output ready);
endinterface

// File: design/set_assoc_writeback_cache_lru_top.sv
// ----------------------------------------------------------------------------
// set_assoc_writeback_cache_lru_top
// Tag/state store of a set-associative write-back write-allocate cache with
// true LRU. One RAM row per set holds tag, rank, dirty and valid of all ways.
//
//   channel | dir | word
//   --------+-----+---------------------------------------------------------
//   req     | in  | op, address
//   rsp     | out | hit, way, fill_request/address, writeback_request/
//           |     | address, invalidated_dirty
//
// A request is handled as a set row read, then compare/update/write back
// of the same row. After reset a clearing pass writes 2**SET_BITS zero rows,
// one per cycle, with req.ready low. A held result stalls the update cycle
// only; the next request can be taken while a result waits in rsp.
// ----------------------------------------------------------------------------
module set_assoc_writeback_cache_lru_top #(
  parameter int OFS_BITS = salru_pkg::OFS_BITS_DEF,
  parameter int SET_BITS = salru_pkg::SET_BITS_DEF,
  parameter int WAYS     = salru_pkg::WAYS_DEF
) (
  input logic        clk,
  input logic        rst,
  salru_req_if.sink  req,
  salru_rsp_if.source rsp
);
  import salru_pkg::*;

  localparam int TAG_W     = ADDR_BITS - OFS_BITS - SET_BITS;
  localparam int SET_W     = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int WW        = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int LINE_W    = TAG_W + WW + 2;
  localparam int ROW_W     = WAYS * LINE_W;
  localparam int SET_COUNT = 1 << SET_BITS;
  localparam logic [SET_W-1:0] SET_MASK = SET_W'(SET_COUNT - 1);
  localparam logic [SET_W-1:0] LAST_SET = SET_W'(SET_COUNT - 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;

  logic [1:0]       state;
  logic [SET_W-1:0] clr_idx;
  op_t              op_q;
  addr_t            addr_q;
  logic             rsp_valid;
  rsp_t             rsp_q;

  logic             accept;
  logic             issue;
  logic             ram_we;
  logic [SET_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata;
  logic [SET_W-1:0] rd_set;
  logic [ROW_W-1:0] row_rd;
  logic [ROW_W-1:0] row_next;
  logic             lk_we;
  rsp_t             lk_result;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign issue     = (state == ST_LOOK) && (!rsp_valid || rsp.ready);
  assign rd_set    = SET_W'(req.address >> OFS_BITS) & SET_MASK;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = SET_W'(addr_q >> OFS_BITS) & SET_MASK;
    ram_wdata = row_next;
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx;
      ram_wdata = '0;
    end else if (issue) begin
      ram_we = lk_we;
    end
  end

  salru_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SET_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (rd_set),
    .rdata (row_rd)
  );

  salru_lookup #(
    .OFS_BITS (OFS_BITS),
    .SET_BITS (SET_BITS),
    .WAYS     (WAYS),
    .ROW_W    (ROW_W)
  ) u_lookup (
    .row      (row_rd),
    .op       (op_q),
    .address  (addr_q),
    .row_next (row_next),
    .we       (lk_we),
    .result   (lk_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST_SET) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (issue) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (issue) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= req.op;
      addr_q <= req.address;
    end
    if (issue) begin
      rsp_q <= lk_result;
    end
  end

  assign rsp.valid             = rsp_valid;
  assign rsp.hit               = rsp_q.hit;
  assign rsp.way               = rsp_q.way;
  assign rsp.fill_request      = rsp_q.fill_request;
  assign rsp.fill_address      = rsp_q.fill_address;
  assign rsp.writeback_request = rsp_q.writeback_request;
  assign rsp.writeback_address = rsp_q.writeback_address;
  assign rsp.invalidated_dirty = rsp_q.invalidated_dirty;

endmodule

// File: design/salru_ram.sv
// ----------------------------------------------------------------------------
// salru_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module salru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/salru_lookup.sv
// ----------------------------------------------------------------------------
// salru_lookup
// Tag compare, victim choice and LRU/valid/dirty update of one set row.
// Produces the updated row, its write enable and the result word.
// ----------------------------------------------------------------------------
module salru_lookup #(
  parameter int OFS_BITS = salru_pkg::OFS_BITS_DEF,
  parameter int SET_BITS = salru_pkg::SET_BITS_DEF,
  parameter int WAYS     = salru_pkg::WAYS_DEF,
  parameter int ROW_W    = 4
) (
  input  logic [ROW_W-1:0] row,
  input  salru_pkg::op_t   op,
  input  salru_pkg::addr_t address,
  output logic [ROW_W-1:0] row_next,
  output logic             we,
  output salru_pkg::rsp_t  result
);
  import salru_pkg::*;

  localparam int TAG_W  = ADDR_BITS - OFS_BITS - SET_BITS;
  localparam int SET_W  = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int WW     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int LINE_W = TAG_W + WW + 2;
  localparam logic [SET_W-1:0] SET_MASK = SET_W'((1 << SET_BITS) - 1);

  logic [TAG_W-1:0] tag_r   [WAYS];
  logic [WW-1:0]    rank_r  [WAYS];
  logic             dirty_r [WAYS];
  logic             valid_r [WAYS];

  logic [TAG_W-1:0] tag;
  logic [SET_W-1:0] set_idx;
  logic [WAYS-1:0]  hit_vec;
  logic [WAYS-1:0]  lru_vec;
  logic             found;
  logic             have_inv;
  logic [WW-1:0]    hit_way;
  logic [WW-1:0]    inv_way;
  logic [WW-1:0]    lru_way;
  logic [WW-1:0]    miss_way;
  logic [WW-1:0]    touch_way;
  logic [WW-1:0]    old_rank;
  logic [WW+1:0]    way_ext;
  logic             is_access;
  logic             is_write;

  assign tag     = address[ADDR_BITS-1 -: TAG_W];
  assign set_idx = SET_W'(address >> OFS_BITS) & SET_MASK;

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      tag_r[i]   = row[i*LINE_W +: TAG_W];
      rank_r[i]  = row[i*LINE_W + TAG_W +: WW];
      dirty_r[i] = row[i*LINE_W + TAG_W + WW];
      valid_r[i] = row[i*LINE_W + TAG_W + WW + 1];
    end
  end

  // first way holding the minimum rank
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      hit_vec[i] = valid_r[i] && (tag_r[i] == tag);
      lru_vec[i] = 1'b1;
      for (int j = 0; j < WAYS; j++) begin
        if (j < i && rank_r[j] <= rank_r[i]) begin
          lru_vec[i] = 1'b0;
        end
        if (j > i && rank_r[j] < rank_r[i]) begin
          lru_vec[i] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    found    = 1'b0;
    have_inv = 1'b0;
    hit_way  = '0;
    inv_way  = '0;
    lru_way  = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        found   = 1'b1;
        hit_way = WW'(i);
      end
      if (!valid_r[i]) begin
        have_inv = 1'b1;
        inv_way  = WW'(i);
      end
      if (lru_vec[i]) begin
        lru_way = WW'(i);
      end
    end
  end

  assign miss_way  = have_inv ? inv_way : lru_way;
  assign touch_way = found ? hit_way : miss_way;
  assign old_rank  = rank_r[touch_way];
  assign is_access = (op == OP_READ) || (op == OP_WRITE);
  assign is_write  = (op == OP_WRITE);

  always_comb begin
    row_next = row;
    we       = 1'b0;
    result   = '0;
    way_ext  = '0;
    unique case (op)
      OP_READ, OP_WRITE: begin
        we = 1'b1;
        for (int i = 0; i < WAYS; i++) begin
          if (rank_r[i] > old_rank) begin
            row_next[i*LINE_W + TAG_W +: WW] = rank_r[i] - 1'b1;
          end
        end
        row_next[touch_way*LINE_W + TAG_W +: WW] = WW'(WAYS - 1);
        way_ext = (WW+2)'(touch_way);
        result.way = way_ext[1:0];
        if (found) begin
          result.hit = 1'b1;
          if (is_write) begin
            row_next[touch_way*LINE_W + TAG_W + WW] = 1'b1;
          end
        end else begin
          row_next[touch_way*LINE_W +: TAG_W]          = tag;
          row_next[touch_way*LINE_W + TAG_W + WW]      = is_write;
          row_next[touch_way*LINE_W + TAG_W + WW + 1]  = 1'b1;
          result.fill_request = 1'b1;
          result.fill_address = address;
          if (!have_inv && dirty_r[lru_way]) begin
            result.writeback_request = 1'b1;
            result.writeback_address =
              (ADDR_BITS'(tag_r[lru_way]) << (OFS_BITS + SET_BITS)) |
              (ADDR_BITS'(set_idx) << OFS_BITS);
          end
        end
      end
      OP_INVAL: begin
        if (found) begin
          we = 1'b1;
          row_next[hit_way*LINE_W + TAG_W + WW]     = 1'b0;
          row_next[hit_way*LINE_W + TAG_W + WW + 1] = 1'b0;
          way_ext = (WW+2)'(hit_way);
          result.hit               = 1'b1;
          result.way               = way_ext[1:0];
          result.invalidated_dirty = dirty_r[hit_way];
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
    if (!is_access && op != OP_INVAL) begin
      we = 1'b0;
    end
  end

endmodule

// File: tb/sv/salru_lookup_checker.sv
// ----------------------------------------------------------------------------
// salru_lookup_checker
// Watches the request and result channels of the cache tag store. Every
// accepted request word is run through a local copy of the tag, valid, dirty
// and LRU-rank arrays, and the predicted lookup result is queued. Each
// accepted result word is compared field by field with the oldest queued
// prediction. Mismatch and pending counts go back to the testbench top.
// ----------------------------------------------------------------------------
module salru_lookup_checker #(
  parameter int OFS_BITS = salru_pkg::OFS_BITS_DEF,
  parameter int SET_BITS = salru_pkg::SET_BITS_DEF,
  parameter int WAYS     = salru_pkg::WAYS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  salru_req_if  req,
  salru_rsp_if  rsp,
  output int    mismatches,
  output int    outstanding
);
  import salru_pkg::*;

  localparam int NSETS  = 1 << SET_BITS;
  localparam int TAG_W  = ADDR_BITS - OFS_BITS - SET_BITS;
  localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  typedef logic [TAG_W-1:0]  tag_t;
  typedef logic [RANK_W-1:0] rank_t;

  tag_t  line_tag   [NSETS][WAYS];
  bit    line_valid [NSETS][WAYS];
  bit    line_dirty [NSETS][WAYS];
  rank_t line_rank  [NSETS][WAYS];

  rsp_t  lookup_q[$];
  int    err_seen;

  initial begin
    err_seen = 0;
  end

  // make way w the most recent; ranks above its old rank drop by one
  function automatic void promote_way(int s, int w);
    rank_t old_rank;
    old_rank = line_rank[s][w];
    for (int i = 0; i < WAYS; i++) begin
      if (line_rank[s][i] > old_rank) line_rank[s][i] = line_rank[s][i] - 1'b1;
    end
    line_rank[s][w] = rank_t'(WAYS - 1);
  endfunction

  function automatic rsp_t predict_lookup(op_t op, addr_t a);
    rsp_t res;
    int   s;
    int   w;
    bit   found;
    bit   have_free;
    tag_t tag;
    res   = '0;
    s     = int'((a >> OFS_BITS) & addr_t'(NSETS - 1));
    tag   = tag_t'(a >> (OFS_BITS + SET_BITS));
    found = 1'b0;
    w     = 0;
    if (op != OP_READ && op != OP_WRITE && op != OP_INVAL) return res;

    for (int i = 0; i < WAYS; i++) begin
      if (!found && line_valid[s][i] && line_tag[s][i] == tag) begin
        found = 1'b1;
        w     = i;
      end
    end

    if (op == OP_INVAL) begin
      if (found) begin
        res.hit               = 1'b1;
        res.way               = way_out_t'(w);
        res.invalidated_dirty = line_dirty[s][w];
        line_valid[s][w]      = 1'b0;
        line_dirty[s][w]      = 1'b0;
      end
      return res;
    end

    if (found) begin
      if (op == OP_WRITE) line_dirty[s][w] = 1'b1;
      promote_way(s, w);
      res.hit = 1'b1;
      res.way = way_out_t'(w);
      return res;
    end

    // miss: lowest free way, else lowest-ranked way (lowest index on tie)
    have_free = 1'b0;
    for (int i = 0; i < WAYS; i++) begin
      if (!have_free && !line_valid[s][i]) begin
        have_free = 1'b1;
        w         = i;
      end
    end
    if (!have_free) begin
      w = 0;
      for (int i = 1; i < WAYS; i++) begin
        if (line_rank[s][i] < line_rank[s][w]) w = i;
      end
      if (line_dirty[s][w]) begin
        res.writeback_request = 1'b1;
        res.writeback_address = (addr_t'(line_tag[s][w]) << (OFS_BITS + SET_BITS)) |
                                (addr_t'(s) << OFS_BITS);
      end
    end

    line_tag[s][w]   = tag;
    line_valid[s][w] = 1'b1;
    line_dirty[s][w] = (op == OP_WRITE);
    promote_way(s, w);

    res.way          = way_out_t'(w);
    res.fill_request = 1'b1;
    res.fill_address = a;
    return res;
  endfunction

  always @(posedge clk) begin : track
    rsp_t want;
    rsp_t got;
    if (rst) begin
      for (int s = 0; s < NSETS; s++) begin
        for (int i = 0; i < WAYS; i++) begin
          line_tag[s][i]   = '0;
          line_valid[s][i] = 1'b0;
          line_dirty[s][i] = 1'b0;
          line_rank[s][i]  = '0;
        end
      end
      lookup_q.delete();
      outstanding <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got.hit               = rsp.hit;
        got.way               = rsp.way;
        got.fill_request      = rsp.fill_request;
        got.fill_address      = rsp.fill_address;
        got.writeback_request = rsp.writeback_request;
        got.writeback_address = rsp.writeback_address;
        got.invalidated_dirty = rsp.invalidated_dirty;
        if (lookup_q.size() == 0) begin
          err_seen++;
          if (err_seen <= 10)
            $display("mismatch: result word with no lookup pending: hit=%0b way=%0d",
                     got.hit, got.way);
        end else begin
          want = lookup_q.pop_front();
          if (got.hit !== want.hit || got.way !== want.way ||
              got.fill_request !== want.fill_request ||
              got.fill_address !== want.fill_address ||
              got.writeback_request !== want.writeback_request ||
              got.writeback_address !== want.writeback_address ||
              got.invalidated_dirty !== want.invalidated_dirty) begin
            err_seen++;
            if (err_seen <= 10)
              $display({"mismatch: exp hit=%0b way=%0d fill=%0b/%h wb=%0b/%h idirty=%0b",
                        " | got hit=%0b way=%0d fill=%0b/%h wb=%0b/%h idirty=%0b"},
                       want.hit, want.way, want.fill_request, want.fill_address,
                       want.writeback_request, want.writeback_address,
                       want.invalidated_dirty,
                       got.hit, got.way, got.fill_request, got.fill_address,
                       got.writeback_request, got.writeback_address,
                       got.invalidated_dirty);
          end
        end
      end
      if (req.valid && req.ready) lookup_q = {lookup_q, predict_lookup(req.op, req.address)};
      outstanding <= lookup_q.size();
      mismatches  <= err_seen;
    end
  end

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the set-associative write-back cache tag store.
// A directed pass walks fills, hits, dirty evictions, invalidates and the
// ignored op; a random pass hammers a few hot sets with a small tag pool so
// that hits, LRU evictions and writebacks are frequent. Both channels idle at
// random; one long result stall backs the block up, and the request side
// drains fully after each pass and within the random pass; salru_lookup_checker checks.
// ----------------------------------------------------------------------------
module tb_top;
  import salru_pkg::*;

  localparam int OFS_BITS     = OFS_BITS_DEF;
  localparam int SET_BITS     = SET_BITS_DEF;
  localparam int WAYS         = WAYS_DEF;
  localparam int NSETS        = 1 << SET_BITS;
  localparam int TAG_W        = ADDR_BITS - OFS_BITS - SET_BITS;
  localparam int RANDOM_WORDS = 600;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE       = 20;
  localparam int CYCLE_LIMIT  = 500000;

  localparam op_t OP_IGNORED = 2'd3;

  typedef logic [TAG_W-1:0] tag_t;

  logic clk = 1'b0;
  logic rst;
  int   mismatch_count;
  int   pending_lookups;
  int   cycle_count = 0;
  int   hold_ticket = 0;

  always #1 clk = ~clk;

  salru_req_if req_if ();
  salru_rsp_if rsp_if ();

  set_assoc_writeback_cache_lru_top #(
    .OFS_BITS (OFS_BITS),
    .SET_BITS (SET_BITS),
    .WAYS     (WAYS)
  ) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  salru_lookup_checker #(
    .OFS_BITS (OFS_BITS),
    .SET_BITS (SET_BITS),
    .WAYS     (WAYS)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req_if),
    .rsp         (rsp_if),
    .mismatches  (mismatch_count),
    .outstanding (pending_lookups)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic addr_t mk_addr(tag_t tag, int s, int off);
    return (addr_t'(tag) << (OFS_BITS + SET_BITS)) |
           (addr_t'(s & (NSETS - 1)) << OFS_BITS) |
           addr_t'(off & ((1 << OFS_BITS) - 1));
  endfunction

  task automatic send_word(op_t op, addr_t a);
    req_if.valid   <= 1'b1;
    req_if.op      <= op;
    req_if.address <= a;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_lookups != 0) @(posedge clk);
  endtask

  // result side: random stalls, calm stretches, and long holds on request
  initial begin : result_drain
    int stall_left;
    int calm_left;
    int hold_served;
    int r;
    stall_left    = 0;
    calm_left     = 0;
    hold_served   = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_ticket) begin
        hold_served++;
        rsp_if.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready <= 1'b1;
        if (calm_left > 0) begin
          calm_left--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 25)      stall_left = $urandom_range(1, 3);
          else if (r < 29) stall_left = $urandom_range(10, 40);
          else if (r < 35) calm_left  = $urandom_range(20, 80);
        end
      end
    end
  end

  initial begin : stimulus
    tag_t tag_pool[6];
    int   hot_set[4];
    int   sent;
    int   r;
    int   gap;
    int   burst_left;
    op_t  op;
    addr_t a;

    req_if.valid   <= 1'b0;
    req_if.op      <= OP_READ;
    req_if.address <= '0;
    rst            <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, fills, LRU eviction of a dirty line, invalidates
    send_word(OP_READ,    32'h0000_0000);
    send_word(OP_WRITE,   32'hFFFF_FFFF);
    send_word(OP_READ,    mk_addr('0, 0, 31));
    send_word(OP_WRITE,   mk_addr(tag_t'(1), 5, 0));
    send_word(OP_WRITE,   mk_addr(tag_t'(2), 5, 4));
    send_word(OP_READ,    mk_addr(tag_t'(3), 5, 8));
    send_word(OP_WRITE,   mk_addr(tag_t'(4), 5, 12));
    send_word(OP_READ,    mk_addr(tag_t'(1), 5, 31));
    send_word(OP_READ,    mk_addr(tag_t'(5), 5, 1));
    send_word(OP_READ,    mk_addr(tag_t'(3), 5, 2));
    send_word(OP_WRITE,   mk_addr(tag_t'(3), 5, 3));
    send_word(OP_INVAL,   mk_addr(tag_t'(4), 5, 0));
    send_word(OP_INVAL,   mk_addr(tag_t'(4), 5, 0));
    send_word(OP_INVAL,   mk_addr(tag_t'(5), 5, 7));
    send_word(OP_READ,    mk_addr(tag_t'(6), 5, 9));
    send_word(OP_IGNORED, 32'hFFFF_FFFF);
    send_word(OP_READ,    mk_addr('1, 0, 0));
    send_word(OP_WRITE,   mk_addr(tag_t'(7), 5, 16));
    send_word(OP_WRITE,   mk_addr(tag_t'(8), 5, 20));
    send_word(OP_INVAL,   mk_addr('1, NSETS - 1, 0));
    wait_drained();

    // random: few hot sets, small tag pool, some fully random addresses
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < 6; i++) tag_pool[i] = tag_t'($urandom());
    hot_set[0] = 0;
    hot_set[1] = NSETS - 1;
    hot_set[2] = $urandom_range(1, NSETS - 2);
    hot_set[3] = $urandom_range(1, NSETS - 2);

    sent       = 0;
    burst_left = 0;
    while (sent < RANDOM_WORDS) begin
      r = $urandom_range(0, 99);
      if (r < 45)      op = OP_READ;
      else if (r < 78) op = OP_WRITE;
      else if (r < 95) op = OP_INVAL;
      else             op = OP_IGNORED;
      if ($urandom_range(0, 99) < 12)
        a = $urandom();
      else
        a = mk_addr(tag_pool[$urandom_range(0, 5)], hot_set[$urandom_range(0, 3)],
                    $urandom_range(0, (1 << OFS_BITS) - 1));
      send_word(op, a);
      if (op != OP_IGNORED) begin
        sent++;
        if (sent == RANDOM_WORDS / 3) begin
          // back the block up: results held, requests keep coming
          hold_ticket <= hold_ticket + 1;
          burst_left   = 80;
        end
        if (sent == 2 * RANDOM_WORDS / 3) wait_drained();
      end

      gap = 0;
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55)      gap = 0;
        else if (r < 85) gap = $urandom_range(1, 3);
        else if (r < 90) gap = $urandom_range(8, 40);
        else if (r < 96) burst_left = $urandom_range(20, 60);
        else             gap = 1;
      end
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0 && pending_lookups == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
